[rtl/frc_pkg.sv]
// ----------------------------------------------------------------------------
// frc_pkg
// shared constants, types and codes for the frequency/recency scored cache
// ----------------------------------------------------------------------------
package frc_pkg;

    localparam int ENTRIES    = 16;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;
    localparam int TIME_BITS  = 32;
    localparam int COUNT_BITS = 16;
    localparam int CAP_BITS   = 5;
    localparam int CAP_RESET  = 16;
    localparam int SCALE_MS   = 1000;

    localparam int IDX_BITS  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_BITS  = $clog2(ENTRIES + 1);
    localparam int CMP_BITS  = (CNT_BITS > CAP_BITS) ? CNT_BITS : CAP_BITS;
    localparam int DEN_BITS  = TIME_BITS + 1;
    localparam int PROD_BITS = COUNT_BITS + DEN_BITS;

    typedef logic [IDX_BITS-1:0]   idx_t;
    typedef logic [CNT_BITS-1:0]   cnt_t;
    typedef logic [KEY_BITS-1:0]   key_t;
    typedef logic [VALUE_BITS-1:0] val_t;
    typedef logic [TIME_BITS-1:0]  ms_t;
    typedef logic [COUNT_BITS-1:0] use_t;
    typedef logic [DEN_BITS-1:0]   den_t;
    typedef logic [PROD_BITS-1:0]  prod_t;

    localparam use_t COUNT_MAX = '1;

    // one slot of the cache
    typedef struct packed {
        logic valid;
        key_t key;
        val_t value;
        use_t count;
        ms_t  touch_ms;
    } entry_t;

    // data written into a slot
    typedef struct packed {
        key_t key;
        val_t value;
        ms_t  now_ms;
    } wdata_t;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_SHIFT,
        OP_TOUCH,
        OP_TOUCH_VAL,
        OP_FILL,
        OP_CLEAR
    } cell_op_t;

    // commands from the controller to the ring of cells
    typedef struct packed {
        logic   shift;
        logic   touch_en;
        logic   touch_value;
        idx_t   touch_idx;
        logic   fill_en;
        idx_t   fill_idx;
        logic   clear_en;
        idx_t   clear_idx;
        wdata_t data;
    } ring_cmd_t;

    // summary of one pass over the ring
    typedef struct packed {
        logic found_ok;
        idx_t found_idx;
        val_t read_value;
        logic free_ok;
        idx_t free_idx;
        cnt_t used;
        logic victim_ok;
        idx_t victim_idx;
        key_t victim_key;
    } scan_res_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_WRITE
    } state_t;

endpackage

[rtl/frc_cell.sv]
// ----------------------------------------------------------------------------
// frc_cell
// one cache slot: holds, shifts from its neighbor, touches, fills or clears
// ----------------------------------------------------------------------------
module frc_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  frc_pkg::cell_op_t op,
    input  frc_pkg::entry_t   neighbor,
    input  frc_pkg::wdata_t   wdata,
    output frc_pkg::entry_t   ent
);

    logic            valid_reg;
    logic            valid_next;
    frc_pkg::key_t   key_reg;
    frc_pkg::key_t   key_next;
    frc_pkg::val_t   value_reg;
    frc_pkg::val_t   value_next;
    frc_pkg::use_t   count_reg;
    frc_pkg::use_t   count_next;
    frc_pkg::ms_t    touch_reg;
    frc_pkg::ms_t    touch_next;
    frc_pkg::use_t   count_inc;

    // saturating use count
    assign count_inc = (count_reg == frc_pkg::COUNT_MAX) ? count_reg
                                                         : count_reg + 1'b1;

    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        value_next = value_reg;
        count_next = count_reg;
        touch_next = touch_reg;
        unique case (op)
            frc_pkg::OP_HOLD:
            begin
            end
            frc_pkg::OP_SHIFT:
            begin
                valid_next = neighbor.valid;
                key_next   = neighbor.key;
                value_next = neighbor.value;
                count_next = neighbor.count;
                touch_next = neighbor.touch_ms;
            end
            frc_pkg::OP_TOUCH:
            begin
                count_next = count_inc;
                touch_next = wdata.now_ms;
            end
            frc_pkg::OP_TOUCH_VAL:
            begin
                value_next = wdata.value;
                count_next = count_inc;
                touch_next = wdata.now_ms;
            end
            frc_pkg::OP_FILL:
            begin
                valid_next = 1'b1;
                key_next   = wdata.key;
                value_next = wdata.value;
                count_next = frc_pkg::use_t'(1);
                touch_next = wdata.now_ms;
            end
            frc_pkg::OP_CLEAR:
            begin
                valid_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
        count_reg <= count_next;
        touch_reg <= touch_next;
    end

    assign ent.valid    = valid_reg;
    assign ent.key      = key_reg;
    assign ent.value    = value_reg;
    assign ent.count    = count_reg;
    assign ent.touch_ms = touch_reg;

endmodule

[rtl/frc_ring.sv]
// ----------------------------------------------------------------------------
// frc_ring
// ring of slot cells; a rotation brings every slot past cell 0 once
// ----------------------------------------------------------------------------
module frc_ring (
    input  logic               clk,
    input  logic               rst_n,
    input  frc_pkg::ring_cmd_t cmd,
    output frc_pkg::entry_t    head
);

    frc_pkg::entry_t   ents [frc_pkg::ENTRIES];
    frc_pkg::cell_op_t ops  [frc_pkg::ENTRIES];

    for (genvar i = 0; i < frc_pkg::ENTRIES; i++)
    begin : g_cell
        localparam int NXT = (i + 1) % frc_pkg::ENTRIES;

        // per-slot decode, shift wins, a fill wins over a clear of the same slot
        always_comb
        begin
            priority if (cmd.shift)
                ops[i] = frc_pkg::OP_SHIFT;
            else if (cmd.fill_en && cmd.fill_idx == frc_pkg::idx_t'(i))
                ops[i] = frc_pkg::OP_FILL;
            else if (cmd.clear_en && cmd.clear_idx == frc_pkg::idx_t'(i))
                ops[i] = frc_pkg::OP_CLEAR;
            else if (cmd.touch_en && cmd.touch_idx == frc_pkg::idx_t'(i))
                ops[i] = cmd.touch_value ? frc_pkg::OP_TOUCH_VAL : frc_pkg::OP_TOUCH;
            else
                ops[i] = frc_pkg::OP_HOLD;
        end

        frc_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .op       (ops[i]),
            .neighbor (ents[NXT]),
            .wdata    (cmd.data),
            .ent      (ents[i])
        );
    end

    assign head = ents[0];

endmodule

[rtl/frc_scan.sv]
// ----------------------------------------------------------------------------
// frc_scan
// shared lookup/score unit fed by the ring head, one slot per cycle of step_en
// ----------------------------------------------------------------------------
module frc_scan (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               step_en,
    input  frc_pkg::entry_t    head,
    input  frc_pkg::idx_t      head_idx,
    input  frc_pkg::key_t      key,
    input  frc_pkg::ms_t       now_ms,
    output frc_pkg::scan_res_t res
);

    // stage a: head snapshot
    logic            snap_live_reg;
    logic            snap_valid_reg;
    logic            snap_match_reg;
    frc_pkg::idx_t   snap_idx_reg;
    frc_pkg::key_t   snap_key_reg;
    frc_pkg::val_t   snap_value_reg;
    frc_pkg::use_t   snap_count_reg;
    frc_pkg::den_t   snap_den_reg;
    frc_pkg::den_t   head_den;

    // stage b: running summary
    logic            found_ok_reg,  found_ok_next;
    frc_pkg::idx_t   found_idx_reg, found_idx_next;
    frc_pkg::val_t   rd_value_reg,  rd_value_next;
    logic            free_ok_reg,   free_ok_next;
    frc_pkg::idx_t   free_idx_reg,  free_idx_next;
    frc_pkg::cnt_t   used_reg,      used_next;
    logic            victim_ok_reg, victim_ok_next;
    frc_pkg::idx_t   victim_idx_reg, victim_idx_next;
    frc_pkg::key_t   victim_key_reg, victim_key_next;
    frc_pkg::use_t   best_count_reg, best_count_next;
    frc_pkg::den_t   best_den_reg,   best_den_next;

    frc_pkg::prod_t  prod_snap;
    frc_pkg::prod_t  prod_best;
    logic            snap_lower;

    // 1000 + age, age modulo 2^32
    assign head_den = frc_pkg::den_t'(frc_pkg::SCALE_MS)
                    + frc_pkg::den_t'(frc_pkg::ms_t'(now_ms - head.touch_ms));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snap_live_reg <= 1'b0;
        end
        else
        begin
            snap_live_reg <= step_en;
        end
    end

    always_ff @(posedge clk)
    begin
        snap_valid_reg <= head.valid;
        snap_match_reg <= head.valid && (head.key == key);
        snap_idx_reg   <= head_idx;
        snap_key_reg   <= head.key;
        snap_value_reg <= head.value;
        snap_count_reg <= head.count;
        snap_den_reg   <= head_den;
    end

    // exact score compare by cross multiplication
    assign prod_snap  = frc_pkg::prod_t'(snap_count_reg) * frc_pkg::prod_t'(best_den_reg);
    assign prod_best  = frc_pkg::prod_t'(best_count_reg) * frc_pkg::prod_t'(snap_den_reg);
    assign snap_lower = prod_snap < prod_best;

    always_comb
    begin
        found_ok_next   = found_ok_reg;
        found_idx_next  = found_idx_reg;
        rd_value_next   = rd_value_reg;
        free_ok_next    = free_ok_reg;
        free_idx_next   = free_idx_reg;
        used_next       = used_reg;
        victim_ok_next  = victim_ok_reg;
        victim_idx_next = victim_idx_reg;
        victim_key_next = victim_key_reg;
        best_count_next = best_count_reg;
        best_den_next   = best_den_reg;
        priority if (start)
        begin
            found_ok_next  = 1'b0;
            free_ok_next   = 1'b0;
            used_next      = '0;
            victim_ok_next = 1'b0;
        end
        else if (snap_live_reg)
        begin
            if (snap_valid_reg)
            begin
                used_next = used_reg + 1'b1;
                if (!found_ok_reg && snap_match_reg)
                begin
                    found_ok_next  = 1'b1;
                    found_idx_next = snap_idx_reg;
                    rd_value_next  = snap_value_reg;
                end
                // strict compare keeps the lowest slot on a tie
                if (!victim_ok_reg || snap_lower)
                begin
                    victim_ok_next  = 1'b1;
                    victim_idx_next = snap_idx_reg;
                    victim_key_next = snap_key_reg;
                    best_count_next = snap_count_reg;
                    best_den_next   = snap_den_reg;
                end
            end
            else if (!free_ok_reg)
            begin
                free_ok_next  = 1'b1;
                free_idx_next = snap_idx_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_ok_reg  <= 1'b0;
            free_ok_reg   <= 1'b0;
            used_reg      <= '0;
            victim_ok_reg <= 1'b0;
        end
        else
        begin
            found_ok_reg  <= found_ok_next;
            free_ok_reg   <= free_ok_next;
            used_reg      <= used_next;
            victim_ok_reg <= victim_ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        found_idx_reg  <= found_idx_next;
        rd_value_reg   <= rd_value_next;
        free_idx_reg   <= free_idx_next;
        victim_idx_reg <= victim_idx_next;
        victim_key_reg <= victim_key_next;
        best_count_reg <= best_count_next;
        best_den_reg   <= best_den_next;
    end

    assign res.found_ok   = found_ok_reg;
    assign res.found_idx  = found_idx_reg;
    assign res.read_value = rd_value_reg;
    assign res.free_ok    = free_ok_reg;
    assign res.free_idx   = free_idx_reg;
    assign res.used       = used_reg;
    assign res.victim_ok  = victim_ok_reg;
    assign res.victim_idx = victim_idx_reg;
    assign res.victim_key = victim_key_reg;

endmodule

[rtl/freq_recency_cache.sv]
// ----------------------------------------------------------------------------
// freq_recency_cache
// fully associative key/value cache with frequency/recency scored eviction
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid/in_ready) carries func (0 get, 1 put), key, value
//   and now_ms; one result transfer (out_valid/out_ready) follows every input
//   transfer: hit, read_value, evicted, evicted_key
//   capacity is written through cfg_we/cfg_wdata; the user must do so only
//   while the block is idle, which the block itself does not enforce; 0 acts
//   as 1, values above the slot count act as the slot count
// operation
//   the slots sit in a ring of cells that rotates once per item; the shared
//   lookup/score unit sees one slot per cycle at the ring head; a drain step
//   then empties the score pipeline and write-back makes the result valid; a
//   new item is taken only when the block is idle again after that write-back
//   scores count*1000/(1000+age) are compared exactly by cross multiplication
// reset
//   all slots invalid, capacity 16, no result pending
// back-pressure
//   a finished result waits in the output register while the next item is
//   already taken and scanned; write-back of that item holds until the output
//   register is free
// ----------------------------------------------------------------------------
module freq_recency_cache (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration
    input  logic                               cfg_we,
    input  logic [frc_pkg::CAP_BITS-1:0]       cfg_wdata,
    // input channel
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               func,
    input  logic [frc_pkg::KEY_BITS-1:0]       key,
    input  logic [frc_pkg::VALUE_BITS-1:0]     value,
    input  logic [frc_pkg::TIME_BITS-1:0]      now_ms,
    // result channel
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               hit,
    output logic [frc_pkg::VALUE_BITS-1:0]     read_value,
    output logic                               evicted,
    output logic [frc_pkg::KEY_BITS-1:0]       evicted_key
);

    localparam frc_pkg::idx_t LAST_STEP = frc_pkg::idx_t'(frc_pkg::ENTRIES - 1);

    // control
    frc_pkg::state_t state_reg, state_next;
    frc_pkg::idx_t   step_reg,  step_next;
    logic [frc_pkg::CAP_BITS-1:0] capacity_reg, capacity_next;
    logic            out_valid_reg, out_valid_next;

    // item being worked on
    logic            func_reg;
    frc_pkg::key_t   key_reg;
    frc_pkg::val_t   value_reg;
    frc_pkg::ms_t    now_reg;

    // result register
    logic            out_hit_reg;
    frc_pkg::val_t   out_read_value_reg;
    logic            out_evicted_reg;
    frc_pkg::key_t   out_evicted_key_reg;

    logic               in_fire;
    logic               out_free;
    logic               shift;
    logic               commit;
    frc_pkg::entry_t    head;
    frc_pkg::ring_cmd_t ring_cmd;
    frc_pkg::scan_res_t scan_res;

    // write-back decision
    logic [frc_pkg::CMP_BITS-1:0] cap_ext;
    logic [frc_pkg::CMP_BITS-1:0] cap_lim;
    logic            miss_put;
    logic            need_evict;
    logic            evict;
    logic            dst_ok;
    frc_pkg::idx_t   dst_idx;

    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // ---------------- state machine ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            frc_pkg::ST_IDLE:
            begin
                if (in_valid)
                    state_next = frc_pkg::ST_SCAN;
            end
            frc_pkg::ST_SCAN:
            begin
                if (step_reg == LAST_STEP)
                    state_next = frc_pkg::ST_DRAIN;
            end
            frc_pkg::ST_DRAIN:
            begin
                state_next = frc_pkg::ST_WRITE;
            end
            frc_pkg::ST_WRITE:
            begin
                if (out_free)
                    state_next = frc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = frc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        shift    = 1'b0;
        commit   = 1'b0;
        unique case (state_reg)
            frc_pkg::ST_IDLE:  in_ready = 1'b1;
            frc_pkg::ST_SCAN:  shift    = 1'b1;
            frc_pkg::ST_DRAIN:
            begin
            end
            frc_pkg::ST_WRITE: commit   = out_free;
            default:
            begin
            end
        endcase
    end

    // head slot index follows the rotation
    assign step_next = shift ? step_reg + 1'b1 : (in_fire ? '0 : step_reg);

    assign capacity_next = cfg_we ? cfg_wdata : capacity_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= frc_pkg::ST_IDLE;
            step_reg      <= '0;
            capacity_reg  <= frc_pkg::CAP_BITS'(frc_pkg::CAP_RESET);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            capacity_reg  <= capacity_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            func_reg  <= func;
            key_reg   <= key;
            value_reg <= value;
            now_reg   <= now_ms;
        end
    end

    // ---------------- datapath ----------------
    frc_ring u_ring (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (ring_cmd),
        .head  (head)
    );

    frc_scan u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_fire),
        .step_en  (shift),
        .head     (head),
        .head_idx (step_reg),
        .key      (key_reg),
        .now_ms   (now_reg),
        .res      (scan_res)
    );

    // effective capacity, clamped to one .. ENTRIES
    always_comb
    begin
        cap_ext = frc_pkg::CMP_BITS'(capacity_reg);
        if (capacity_reg == '0)
            cap_lim = frc_pkg::CMP_BITS'(1);
        else if (cap_ext > frc_pkg::CMP_BITS'(frc_pkg::ENTRIES))
            cap_lim = frc_pkg::CMP_BITS'(frc_pkg::ENTRIES);
        else
            cap_lim = cap_ext;
    end

    // a new key evicts when full by capacity or by slots; it is written to the
    // lower of victim slot and first free slot if it evicts, else to the first free slot
    always_comb
    begin
        miss_put   = func_reg && !scan_res.found_ok;
        need_evict = miss_put
                  && ((frc_pkg::CMP_BITS'(scan_res.used) >= cap_lim) || !scan_res.free_ok);
        evict      = need_evict && scan_res.victim_ok;
        dst_ok     = miss_put && (evict || scan_res.free_ok);
        if (evict && !(scan_res.free_ok && (scan_res.free_idx < scan_res.victim_idx)))
            dst_idx = scan_res.victim_idx;
        else
            dst_idx = scan_res.free_idx;
    end

    always_comb
    begin
        ring_cmd.shift       = shift;
        ring_cmd.touch_en    = commit && scan_res.found_ok;
        ring_cmd.touch_value = func_reg;
        ring_cmd.touch_idx   = scan_res.found_idx;
        ring_cmd.fill_en     = commit && dst_ok;
        ring_cmd.fill_idx    = dst_idx;
        ring_cmd.clear_en    = commit && evict;
        ring_cmd.clear_idx   = scan_res.victim_idx;
        ring_cmd.data.key    = key_reg;
        ring_cmd.data.value  = value_reg;
        ring_cmd.data.now_ms = now_reg;
    end

    // ---------------- result register ----------------
    always_comb
    begin
        if (commit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            out_hit_reg         <= scan_res.found_ok;
            out_read_value_reg  <= (scan_res.found_ok && !func_reg) ? scan_res.read_value
                                                                    : '0;
            out_evicted_reg     <= evict;
            out_evicted_key_reg <= evict ? scan_res.victim_key : '0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign hit         = out_hit_reg;
    assign read_value  = out_read_value_reg;
    assign evicted     = out_evicted_reg;
    assign evicted_key = out_evicted_key_reg;

    // ---------------- assertions ----------------
    // a result only appears right after a write-back
    a_result_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == frc_pkg::ST_WRITE))
        else $error("result raised without write-back");

    // a hit never evicts
    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_hit_reg && out_evicted_reg))
        else $error("hit and eviction on one item");

    // a miss returns no data
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_hit_reg) |-> (out_read_value_reg == '0))
        else $error("read data on a miss");

    // a rotation starts with slot zero at the head
    a_scan_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == frc_pkg::ST_SCAN && $past(state_reg) == frc_pkg::ST_IDLE)
            |-> (step_reg == '0))
        else $error("rotation started off slot zero");

    // the ring is back in place at write-back: no more than ENTRIES slots seen
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == frc_pkg::ST_WRITE)
            |-> (scan_res.used <= frc_pkg::cnt_t'(frc_pkg::ENTRIES)))
        else $error("slot count out of range");

endmodule
